// ===== hw/rtl/scpr_pkg.sv =====
package scpr_pkg;

   // Field widths fixed by the item formats
   localparam int PAGE_W      = 32;
   localparam int FRAME_IDX_W = 4;
   localparam int CNT_W       = 32;
   localparam int CFG_W       = 5;

   // Result tdata: frame_index, evicted_valid, evicted_page, fault_total, padded to bytes
   localparam int RSP_FIELDS_W = FRAME_IDX_W + 1 + PAGE_W + CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Defaults
   localparam int                 DEFAULT_MAX_FRAMES = 16;
   localparam logic [CFG_W-1:0]   CFG_RESET          = CFG_W'(3);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SWEEP,
      ST_VICTIM,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/second_chance_page_replacer.sv =====
// Second-chance (clock) page replacer.
// req channel: one page reference per item (tdata = page number, tlast = last
// reference of a trace). rsp channel: one result per reference (tuser = hit,
// tdata = frame index, evicted flag, evicted page, fault count). csr channel:
// writes the number of frames in use (0 acts as 1, above MAX_FRAMES acts as
// MAX_FRAMES); write it only while no reference is in flight.
// Page tags live in a one-port-read, one-port-write synchronous memory; the
// valid and reference bits are flip-flops. One reference is processed at a
// time and the tag search reads one frame per cycle. A hit ends the search at
// the matching frame, sets its reference bit and stages the result. A miss
// searches all n frames, then sweeps from the hand, clearing each set
// reference bit, up to the first frame that is invalid or has its bit clear;
// that frame is the victim, its new tag is written and the result is staged.
// The block returns to idle before the next reference is taken.
// A finished result waits in the output register while the next reference
// is already being searched; a stalled receiver holds the block only when a
// second result is ready to go out. A reference with tlast clears all frames,
// the hand and the fault count after its result. Reset clears the same state
// and sets the frame count to 3.
module second_chance_page_replacer
   import scpr_pkg::*;
#(
   parameter int MAX_FRAMES = DEFAULT_MAX_FRAMES
) (
   input  logic                   clock,
   input  logic                   reset,
   // reference in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PAGE_W-1:0]      req_tdata,   // [31:0] page_number
   input  logic                   req_tlast,   // last_of_trace
   // result out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [3:0] frame_index, [4] evicted_valid,
                                               // [36:5] evicted_page, [68:37] fault_total
   output logic                   rsp_tuser,   // [0] hit
   // frame count register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_data     // frames_in_use
);

   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = ((IW > CFG_W) ? IW : CFG_W) + 1;

   // Control state
   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        cfg_ff, cfg_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           hand_ff, hand_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [MAX_FRAMES-1:0]   valid_ff, valid_in;
   logic [MAX_FRAMES-1:0]   ref_ff, ref_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic                    last_ff, last_in;
   logic                    res_hit_ff, res_hit_in;
   logic [IW-1:0]           res_frame_ff, res_frame_in;
   logic                    res_ev_valid_ff, res_ev_valid_in;
   logic [PAGE_W-1:0]       res_ev_page_ff, res_ev_page_in;
   logic [CNT_W-1:0]        res_fault_ff, res_fault_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [FRAME_IDX_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic                    rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_W-1:0]       rsp_ev_page_ff, rsp_ev_page_in;
   logic [CNT_W-1:0]        rsp_fault_ff, rsp_fault_in;

   // Tag memory
   logic [PAGE_W-1:0]       tag_mem [MAX_FRAMES];
   logic [PAGE_W-1:0]       rd_data_ff;
   logic [IW-1:0]           rd_addr;
   logic                    tag_we;

   // Helpers
   logic [NW-1:0]           n_active;
   logic [NW-1:0]           idx_inc;
   logic [IW-1:0]           idx_wrap;
   logic [IW-1:0]           hand_start;
   logic [CNT_W-1:0]        cnt_sat;
   logic                    req_take;
   logic                    match;
   logic                    last_idx;
   logic                    skip;
   logic                    out_free;

   // Clamp the frame count to 1..MAX_FRAMES
   always_comb begin
      if (cfg_ff == '0) begin
         n_active = NW'(1);
      end else if (NW'(cfg_ff) > NW'(MAX_FRAMES)) begin
         n_active = NW'(MAX_FRAMES);
      end else begin
         n_active = NW'(cfg_ff);
      end
   end

   assign idx_inc    = NW'(idx_ff) + NW'(1);
   assign idx_wrap   = (idx_inc >= n_active) ? '0 : IW'(idx_inc);
   assign hand_start = (NW'(hand_ff) >= n_active) ? '0 : hand_ff;
   assign cnt_sat    = (cnt_ff == '1) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign req_take   = req_tvalid && req_tready;
   assign match      = valid_ff[idx_ff] && (rd_data_ff == page_ff);
   assign last_idx   = (idx_inc >= n_active);
   assign skip       = valid_ff[idx_ff] && ref_ff[idx_ff];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (match) begin
               state_in = ST_DONE;
            end else if (last_idx) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (!skip) state_in = ST_VICTIM;
         end
         ST_VICTIM: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State machine outputs: input handshake, memory read address, tag write
   always_comb begin
      req_tready = 1'b0;
      rd_addr    = '0;
      tag_we     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SEARCH: rd_addr    = IW'(idx_inc);
         ST_SWEEP:  rd_addr    = idx_ff;
         ST_VICTIM: tag_we     = 1'b1;
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // Datapath and bit updates
   always_comb begin
      cfg_in          = cfg_ff;
      idx_in          = idx_ff;
      hand_in         = hand_ff;
      cnt_in          = cnt_ff;
      valid_in        = valid_ff;
      ref_in          = ref_ff;
      page_in         = page_ff;
      last_in         = last_ff;
      res_hit_in      = res_hit_ff;
      res_frame_in    = res_frame_ff;
      res_ev_valid_in = res_ev_valid_ff;
      res_ev_page_in  = res_ev_page_ff;
      res_fault_in    = res_fault_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_fault_in    = rsp_fault_ff;

      // take a frame count write
      if (csr_valid && csr_ready) cfg_in = csr_data;

      case (state_ff)
         ST_IDLE: begin
            // latch the reference, start the search at frame 0
            if (req_take) begin
               page_in = req_tdata;
               last_in = req_tlast;
               idx_in  = '0;
            end
         end
         ST_SEARCH: begin
            if (match) begin
               ref_in[idx_ff]  = 1'b1;
               res_hit_in      = 1'b1;
               res_frame_in    = idx_ff;
               res_ev_valid_in = 1'b0;
               res_ev_page_in  = '0;
               res_fault_in    = cnt_ff;
               if (last_ff) begin
                  valid_in = '0;
                  ref_in   = '0;
                  hand_in  = '0;
                  cnt_in   = '0;
               end
            end else if (last_idx) begin
               // miss: start the sweep at the hand
               idx_in = hand_start;
            end else begin
               idx_in = IW'(idx_inc);
            end
         end
         ST_SWEEP: begin
            // give a second chance: clear the bit and advance
            if (skip) begin
               ref_in[idx_ff] = 1'b0;
               idx_in         = idx_wrap;
            end
         end
         ST_VICTIM: begin
            // load the new page into the victim frame
            res_hit_in      = 1'b0;
            res_frame_in    = idx_ff;
            res_ev_valid_in = valid_ff[idx_ff];
            res_ev_page_in  = valid_ff[idx_ff] ? rd_data_ff : '0;
            res_fault_in    = cnt_sat;
            valid_in[idx_ff] = 1'b1;
            ref_in[idx_ff]   = 1'b1;
            hand_in          = idx_wrap;
            cnt_in           = cnt_sat;
            if (last_ff) begin
               valid_in = '0;
               ref_in   = '0;
               hand_in  = '0;
               cnt_in   = '0;
            end
         end
         ST_DONE: begin
            // move the result into the output register once it is free
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = res_hit_ff;
               rsp_frame_in    = FRAME_IDX_W'(res_frame_ff);
               rsp_ev_valid_in = res_ev_valid_ff;
               rsp_ev_page_in  = res_ev_page_ff;
               rsp_fault_in    = res_fault_ff;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         idx_ff       <= '0;
         hand_ff      <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         ref_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         idx_ff       <= idx_in;
         hand_ff      <= hand_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      last_ff         <= last_in;
      res_hit_ff      <= res_hit_in;
      res_frame_ff    <= res_frame_in;
      res_ev_valid_ff <= res_ev_valid_in;
      res_ev_page_ff  <= res_ev_page_in;
      res_fault_ff    <= res_fault_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_fault_ff    <= rsp_fault_in;
   end

   // Tag memory: write the victim, registered read
   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[idx_ff] <= page_ff;
      rd_data_ff <= tag_mem[rd_addr];
   end

   // Ports
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_fault_ff, rsp_ev_page_ff, rsp_ev_valid_ff,
                                     rsp_frame_ff});

endmodule
